>>> hw/rtl/tsnc_pkg.sv
// shared types and constants for the template section nesting checker
package tsnc_pkg;

    localparam int DEF_STACK_DEPTH   = 16;
    localparam int DEF_NAME_BYTES    = 32;
    localparam int DEF_POSITION_BITS = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MISMATCH    = 3'd1,
        ST_EMPTY_CLOSE = 3'd2,
        ST_TOO_LONG    = 3'd3,
        ST_STACK_FULL  = 3'd4,
        ST_UNFINISHED  = 3'd5
    } t_status;

    typedef struct packed {
        logic lb;
        logic rb;
        logic hash;
        logic slash;
    } t_class;

endpackage

>>> hw/rtl/tsnc_front.sv
// front end: takes bytes, classifies them and tracks line and column
module tsnc_front #(
    parameter int POSITION_BITS = tsnc_pkg::DEF_POSITION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_end_of_file,
    input  logic                     i_queue_full,
    output logic                     o_push,
    output logic [7:0]               o_byte,
    output logic                     o_eof,
    output tsnc_pkg::t_class         o_cls,
    output logic [POSITION_BITS-1:0] o_line,
    output logic [POSITION_BITS-1:0] o_col
);
    import tsnc_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] r_line;
    logic [POSITION_BITS-1:0] r_col;
    logic [POSITION_BITS-1:0] n_line;
    logic [POSITION_BITS-1:0] n_col;
    logic                     accept;

    assign o_stall = i_queue_full;
    assign accept  = i_valid & ~i_queue_full;
    assign o_push  = accept;
    assign o_byte  = i_text_byte;
    assign o_eof   = i_end_of_file;
    assign o_line  = r_line;
    assign o_col   = r_col;

    always_comb begin
        o_cls.lb    = (i_text_byte == CH_LBRACE);
        o_cls.rb    = (i_text_byte == CH_RBRACE);
        o_cls.hash  = (i_text_byte == CH_HASH);
        o_cls.slash = (i_text_byte == CH_SLASH);
    end

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (i_text_byte == CH_NEWLINE) begin
            if (r_line != POS_MAX) begin
                n_line = r_line + POSITION_BITS'(1);
            end
            n_col = '0;
        end else if (r_col != POS_MAX) begin
            n_col = r_col + POSITION_BITS'(1);
        end
        // positions start over with the next file
        if (i_end_of_file) begin
            n_line = '0;
            n_col  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_col  <= '0;
        end else if (accept) begin
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

>>> hw/rtl/tsnc_queue.sv
// short first-in first-out queue between the front and back ends
module tsnc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tsnc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import tsnc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/tsnc_back.sv
// back end: tag scanner, section stack and result register
module tsnc_back #(
    parameter int STACK_DEPTH   = tsnc_pkg::DEF_STACK_DEPTH,
    parameter int NAME_BYTES    = tsnc_pkg::DEF_NAME_BYTES,
    parameter int POSITION_BITS = tsnc_pkg::DEF_POSITION_BITS,
    localparam int TOPW         = $clog2(STACK_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    output logic                     o_pop,
    input  logic [7:0]               i_byte,
    input  logic                     i_eof,
    input  tsnc_pkg::t_class         i_cls,
    input  logic [POSITION_BITS-1:0] i_line,
    input  logic [POSITION_BITS-1:0] i_col,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_status,
    output logic [TOPW-1:0]          o_open_depth,
    output logic [POSITION_BITS-1:0] o_line_number,
    output logic [POSITION_BITS-1:0] o_column_number,
    output logic [POSITION_BITS-1:0] o_opened_line,
    output logic [POSITION_BITS-1:0] o_opened_column
);
    import tsnc_pkg::*;

    localparam int TW   = $clog2(STACK_DEPTH);
    localparam int LW   = $clog2(NAME_BYTES);
    localparam int LENW = $clog2(NAME_BYTES + 1);
    localparam int AW   = TW + LW;
    localparam int PB   = POSITION_BITS;
    localparam int EW   = 2 * PB + LENW;
    localparam logic [LENW-1:0] NB_MAX   = LENW'(NAME_BYTES);
    localparam logic [TOPW-1:0] TOP_FULL = TOPW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_B1,
        PH_B2,
        PH_NAME,
        PH_NAME_L1,
        PH_NAME_L2,
        PH_NAME_R
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_OPEN,
        KIND_CLOSE
    } t_kind;

    // name bytes, one row of 2^LW bytes per stack entry
    logic [7:0]    r_name_mem  [1 << AW];
    // opened line, column and name length of each entry
    logic [EW-1:0] r_entry_mem [STACK_DEPTH];

    t_phase          r_phase, n_phase;
    t_kind           r_kind, n_kind;
    logic [LENW-1:0] r_len, n_len;
    logic            r_differs, n_differs;
    logic            r_spec, n_spec;
    logic            r_pend, n_pend;
    logic            r_pend_spec, n_pend_spec;
    logic [7:0]      r_cmp_byte, n_cmp_byte;
    logic [7:0]      r_rd_byte;
    logic [EW-1:0]   r_em_rd;
    logic [TOPW-1:0] r_top, n_top;
    t_status         r_err, n_err;
    logic [PB-1:0]   r_top_line, n_top_line;
    logic [PB-1:0]   r_top_col, n_top_col;
    logic [LENW-1:0] r_top_len, n_top_len;

    logic            r_out_valid;
    logic [2:0]      r_status, n_status;
    logic [TOPW-1:0] r_depth, n_depth;
    logic [PB-1:0]   r_line, r_col, r_oline, r_ocol;
    logic [PB-1:0]   n_oline, n_ocol;

    logic            advance;
    logic            mism;
    logic            do_app, do_spec, do_finish, do_start;
    t_kind           start_kind;
    logic [LENW-1:0] app_len;
    logic [TOPW-1:0] top_m1, top_m2;
    logic            nm_we, nm_re;
    logic [AW-1:0]   nm_waddr, nm_raddr;
    logic [7:0]      nm_wdata;
    logic            em_we;

    assign advance = ~i_empty & (~r_out_valid | ~i_stall);
    assign o_pop   = advance;
    assign top_m1  = r_top - TOPW'(1);
    assign top_m2  = r_top - TOPW'(2);
    assign mism    = (r_rd_byte != r_cmp_byte);

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_len       = r_len;
        n_top       = r_top;
        n_err       = r_err;
        // a compare issued last cycle lands in the name or the held-brace flag
        n_differs   = r_differs | (r_pend & ~r_pend_spec & mism);
        n_spec      = r_spec | (r_pend & r_pend_spec & mism);
        n_pend      = 1'b0;
        n_pend_spec = r_pend_spec;
        n_cmp_byte  = r_cmp_byte;
        n_top_line  = r_top_line;
        n_top_col   = r_top_col;
        n_top_len   = r_top_len;
        do_app      = 1'b0;
        do_spec     = 1'b0;
        do_finish   = 1'b0;
        do_start    = 1'b0;
        start_kind  = KIND_NONE;
        app_len     = r_len;
        nm_we       = 1'b0;
        nm_re       = 1'b0;
        nm_waddr    = '0;
        nm_raddr    = '0;
        nm_wdata    = i_byte;
        em_we       = 1'b0;

        if (advance && r_err == ST_OK) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_cls.lb) begin
                        n_phase = PH_B1;
                    end
                end
                PH_B1: begin
                    n_phase = i_cls.lb ? PH_B2 : PH_IDLE;
                end
                PH_B2: begin
                    if (i_cls.hash) begin
                        do_start   = 1'b1;
                        start_kind = KIND_OPEN;
                    end else if (i_cls.slash) begin
                        do_start   = 1'b1;
                        start_kind = KIND_CLOSE;
                    end else if (!i_cls.lb) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_NAME, PH_NAME_L1: begin
                    if (r_phase == PH_NAME_L1 && i_cls.lb) begin
                        do_app  = 1'b1;
                        n_phase = PH_NAME_L2;
                    end else if (i_cls.rb) begin
                        n_phase = PH_NAME_R;
                        do_spec = 1'b1;
                    end else begin
                        do_app  = 1'b1;
                        n_phase = i_cls.lb ? PH_NAME_L1 : PH_NAME;
                    end
                end
                PH_NAME_L2: begin
                    if (i_cls.hash) begin
                        do_start   = 1'b1;
                        start_kind = KIND_OPEN;
                    end else if (i_cls.slash) begin
                        do_start   = 1'b1;
                        start_kind = KIND_CLOSE;
                    end else if (i_cls.lb) begin
                        do_app = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        n_kind  = KIND_NONE;
                    end
                end
                PH_NAME_R: begin
                    if (i_cls.rb) begin
                        do_finish = 1'b1;
                    end else if (r_len >= NB_MAX) begin
                        n_err   = ST_TOO_LONG;
                        n_phase = PH_IDLE;
                        n_kind  = KIND_NONE;
                    end else begin
                        // the held brace joins the name, then this byte follows it
                        n_differs = n_differs | n_spec;
                        app_len   = r_len + LENW'(1);
                        do_app    = 1'b1;
                        n_phase   = i_cls.lb ? PH_NAME_L1 : PH_NAME;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_kind  = KIND_NONE;
                end
            endcase
        end

        if (do_start) begin
            n_kind    = start_kind;
            n_len     = '0;
            n_differs = 1'b0;
            n_spec    = 1'b0;
            n_pend    = 1'b0;
            n_phase   = PH_NAME;
        end

        // first brace of a possible end: store or check it ahead of time
        if (do_spec && r_len < NB_MAX) begin
            if (r_kind == KIND_OPEN) begin
                if (r_top < TOP_FULL) begin
                    nm_we    = 1'b1;
                    nm_waddr = {r_top[TW-1:0], r_len[LW-1:0]};
                    nm_wdata = CH_RBRACE;
                end
            end else begin
                n_spec = 1'b0;
                if (r_top != '0 && r_len < r_top_len) begin
                    nm_re       = 1'b1;
                    nm_raddr    = {top_m1[TW-1:0], r_len[LW-1:0]};
                    n_pend      = 1'b1;
                    n_pend_spec = 1'b1;
                    n_cmp_byte  = CH_RBRACE;
                end else begin
                    n_spec = 1'b1;
                end
            end
        end

        if (do_app) begin
            if (app_len >= NB_MAX) begin
                n_err   = ST_TOO_LONG;
                n_phase = PH_IDLE;
                n_kind  = KIND_NONE;
            end else begin
                n_len = app_len + LENW'(1);
                if (r_kind == KIND_OPEN) begin
                    if (r_top < TOP_FULL) begin
                        nm_we    = 1'b1;
                        nm_waddr = {r_top[TW-1:0], app_len[LW-1:0]};
                        nm_wdata = i_byte;
                    end
                end else if (r_top != '0 && app_len < r_top_len) begin
                    nm_re       = 1'b1;
                    nm_raddr    = {top_m1[TW-1:0], app_len[LW-1:0]};
                    n_pend      = 1'b1;
                    n_pend_spec = 1'b0;
                    n_cmp_byte  = i_byte;
                end else begin
                    n_differs = 1'b1;
                end
            end
        end

        if (do_finish) begin
            n_phase = PH_IDLE;
            n_kind  = KIND_NONE;
            if (r_kind == KIND_OPEN) begin
                if (r_top >= TOP_FULL) begin
                    n_err = ST_STACK_FULL;
                end else begin
                    em_we      = 1'b1;
                    n_top_line = i_line;
                    n_top_col  = i_col;
                    n_top_len  = r_len;
                    n_top      = r_top + TOPW'(1);
                end
            end else if (r_top == '0) begin
                n_err = ST_EMPTY_CLOSE;
            end else if (n_differs || r_len != r_top_len) begin
                n_err = ST_MISMATCH;
            end else begin
                // entry below the top was read last cycle
                n_top = top_m1;
                if (r_top >= TOPW'(2)) begin
                    {n_top_line, n_top_col, n_top_len} = r_em_rd;
                end else begin
                    n_top_line = '0;
                    n_top_col  = '0;
                    n_top_len  = '0;
                end
            end
        end

        n_status = n_err;
        if (i_eof && n_err == ST_OK && n_top != '0) begin
            n_status = ST_UNFINISHED;
        end
        n_oline = (n_top != '0) ? n_top_line : '0;
        n_ocol  = (n_top != '0) ? n_top_col : '0;
        // depth reported on the last byte of a file is the depth before the clean-up
        n_depth = n_top;

        // end of file: start the next one from a clean state
        if (advance && i_eof) begin
            n_phase   = PH_IDLE;
            n_kind    = KIND_NONE;
            n_len     = '0;
            n_differs = 1'b0;
            n_spec    = 1'b0;
            n_pend    = 1'b0;
            n_top     = '0;
            n_err     = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            r_name_mem[nm_waddr] <= nm_wdata;
        end
        if (nm_re) begin
            r_rd_byte <= r_name_mem[nm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_we) begin
            r_entry_mem[r_top[TW-1:0]] <= {i_line, i_col, r_len};
        end
        r_em_rd <= r_entry_mem[top_m2[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= KIND_NONE;
            r_len       <= '0;
            r_differs   <= 1'b0;
            r_spec      <= 1'b0;
            r_pend      <= 1'b0;
            r_top       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_len       <= n_len;
            r_differs   <= n_differs;
            r_spec      <= n_spec;
            r_pend      <= n_pend;
            r_top       <= n_top;
            r_err       <= n_err;
            r_pend_spec <= n_pend_spec;
            r_cmp_byte  <= n_cmp_byte;
            r_top_line  <= n_top_line;
            r_top_col   <= n_top_col;
            r_top_len   <= n_top_len;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_depth     <= n_depth;
                r_line      <= i_line;
                r_col       <= i_col;
                r_oline     <= n_oline;
                r_ocol      <= n_ocol;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_open_depth    = r_depth;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;
    assign o_opened_line   = r_oline;
    assign o_opened_column = r_ocol;

endmodule

>>> hw/rtl/template_section_nesting_checker.sv
// top level of the template section nesting checker
//
// Checks that section tags in template text nest properly. Bytes come in on
// the input channel (i_valid, o_stall, i_text_byte, i_end_of_file), one per
// transfer; every byte gives exactly one result on the output channel
// (o_valid, i_stall, status, open depth, current position and the position
// where the top or expected section was opened).
// o_valid rises once an input transfer has passed the queue and the output
// register, and while i_stall is low one byte per cycle is sustained: the
// front end and the tag scanner each take one byte per cycle, and the
// scanner's single name-memory port is touched at most once per byte.
// A four-entry queue sits between the front end and the scanner, and the
// result sits in an output register. While i_stall is high the queue fills;
// o_stall rises once it is full and falls as soon as results drain.
// Reset (synchronous, active low) clears the scanner, the stack pointer,
// positions and the queue; the stack memories need no clearing.
// The byte marked end of file returns scanner and position state to the reset
// condition for the next file once its own result has been formed.
module template_section_nesting_checker #(
    parameter int STACK_DEPTH   = tsnc_pkg::DEF_STACK_DEPTH,
    parameter int NAME_BYTES    = tsnc_pkg::DEF_NAME_BYTES,
    parameter int POSITION_BITS = tsnc_pkg::DEF_POSITION_BITS,
    localparam int TOPW         = $clog2(STACK_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_end_of_file,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_status,
    output logic [TOPW-1:0]          o_open_depth,
    output logic [POSITION_BITS-1:0] o_line_number,
    output logic [POSITION_BITS-1:0] o_column_number,
    output logic [POSITION_BITS-1:0] o_opened_line,
    output logic [POSITION_BITS-1:0] o_opened_column
);
    import tsnc_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int QW = 8 + 1 + $bits(t_class) + 2 * PB;

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic [7:0]      f_byte;
    logic            f_eof;
    t_class          f_cls;
    logic [PB-1:0]   f_line;
    logic [PB-1:0]   f_col;
    logic [QW-1:0]   q_in;
    logic [QW-1:0]   q_out;
    logic [7:0]      b_byte;
    logic            b_eof;
    t_class          b_cls;
    logic [PB-1:0]   b_line;
    logic [PB-1:0]   b_col;

    tsnc_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .i_end_of_file(i_end_of_file),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_byte       (f_byte),
        .o_eof        (f_eof),
        .o_cls        (f_cls),
        .o_line       (f_line),
        .o_col        (f_col)
    );

    assign q_in = {f_byte, f_eof, f_cls, f_line, f_col};

    tsnc_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    assign {b_byte, b_eof, b_cls, b_line, b_col} = q_out;

    tsnc_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .NAME_BYTES   (NAME_BYTES),
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .i_byte         (b_byte),
        .i_eof          (b_eof),
        .i_cls          (b_cls),
        .i_line         (b_line),
        .i_col          (b_col),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_open_depth   (o_open_depth),
        .o_line_number  (o_line_number),
        .o_column_number(o_column_number),
        .o_opened_line  (o_opened_line),
        .o_opened_column(o_opened_column)
    );

endmodule

>>> tb/template_section_nesting_checker_tb.sv
// self-checking testbench for the template section nesting checker
module template_section_nesting_checker_tb;
    import tsnc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = DEF_STACK_DEPTH;
    localparam int NBYTES  = DEF_NAME_BYTES;
    localparam int PBITS   = DEF_POSITION_BITS;
    localparam int DEPTH_W = $clog2(DEPTH + 1);
    localparam int POS_MAX = (1 << PBITS) - 1;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_BRACE1,
        SC_BRACE2,
        SC_NAME,
        SC_NAME_LB1,
        SC_NAME_LB2,
        SC_NAME_RB
    } t_scan_state;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_OPEN,
        TAG_CLOSE
    } t_tag_kind;

    typedef struct packed {
        t_status            status;
        logic [DEPTH_W-1:0] depth;
        logic [PBITS-1:0]   line;
        logic [PBITS-1:0]   col;
        logic [PBITS-1:0]   open_line;
        logic [PBITS-1:0]   open_col;
    } t_nest_result;

    typedef struct packed {
        logic [7:0]   text_byte;
        logic         eof;
        logic         typed;
        t_nest_result want;
    } t_dir_row;

    localparam t_nest_result UNTYPED = '0;

    // hand-written rows: expected values given only where they are obvious
    localparam t_dir_row DIRECTED [31] = '{
        // open after a brace run, newline, close with the wrong name
        '{8'h78,      1'b0, 1'b1, '{ST_OK, 0, 0, 0, 0, 0}},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_HASH,    1'b0, 1'b0, UNTYPED},
        '{8'h61,      1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b1, '{ST_OK, 1, 0, 7, 0, 7}},
        '{CH_NEWLINE, 1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_SLASH,   1'b0, 1'b0, UNTYPED},
        '{8'h62,      1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b1, '{ST_MISMATCH, 1, 1, 5, 0, 7}},
        '{8'hFF,      1'b1, 1'b1, '{ST_MISMATCH, 1, 1, 6, 0, 7}},
        // cancelled tag, then a close with nothing open
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{8'h7A,      1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_SLASH,   1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b1, '{ST_EMPTY_CLOSE, 0, 0, 7, 0, 0}},
        '{8'h00,      1'b1, 1'b1, '{ST_EMPTY_CLOSE, 0, 0, 8, 0, 0}},
        // empty name left open at end of file
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_HASH,    1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE,  1'b0, 1'b1, '{ST_OK, 1, 0, 4, 0, 4}},
        '{8'h71,      1'b1, 1'b1, '{ST_UNFINISHED, 1, 0, 5, 0, 4}}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [7:0]          i_text_byte = 8'h00;
    logic                i_end_of_file = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [2:0]          o_status;
    logic [DEPTH_W-1:0]  o_open_depth;
    logic [PBITS-1:0]    o_line_number;
    logic [PBITS-1:0]    o_column_number;
    logic [PBITS-1:0]    o_opened_line;
    logic [PBITS-1:0]    o_opened_column;

    // predictor state
    t_scan_state  sc_state;
    t_tag_kind    sc_kind;
    int unsigned  nm_len;
    bit           nm_diff;
    bit [7:0]     sec_name [DEPTH][NBYTES];
    int unsigned  sec_len [DEPTH];
    int unsigned  sec_line [DEPTH];
    int unsigned  sec_col [DEPTH];
    int unsigned  depth_cnt;
    int unsigned  line_pos;
    int unsigned  col_pos;
    t_status      err_code;

    t_nest_result expected_results [$];
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // stimulus generation
    logic [7:0]   text_q [$];
    logic [7:0]   gen_name [DEPTH+2][NBYTES+4];
    int           gen_len [DEPTH+2];

    template_section_nesting_checker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_text_byte     (i_text_byte),
        .i_end_of_file   (i_end_of_file),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_open_depth    (o_open_depth),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_opened_line   (o_opened_line),
        .o_opened_column (o_opened_column)
    );

    function automatic void clear_checker();
        sc_state  = SC_IDLE;
        sc_kind   = TAG_NONE;
        nm_len    = 0;
        nm_diff   = 1'b0;
        depth_cnt = 0;
        line_pos  = 0;
        col_pos   = 0;
        err_code  = ST_OK;
    endfunction

    function automatic void latch_error(t_status code);
        err_code = code;
        sc_state = SC_IDLE;
        sc_kind  = TAG_NONE;
    endfunction

    function automatic void begin_tag(t_tag_kind kind);
        sc_kind  = kind;
        nm_len   = 0;
        nm_diff  = 1'b0;
        sc_state = SC_NAME;
    endfunction

    // opens store the byte, closes compare it against the top entry
    function automatic void add_name_byte(logic [7:0] b);
        int unsigned e;
        if (nm_len >= NBYTES) begin
            latch_error(ST_TOO_LONG);
            return;
        end
        if (sc_kind == TAG_OPEN) begin
            if (depth_cnt < DEPTH)
                sec_name[depth_cnt][nm_len] = b;
        end else if (depth_cnt > 0) begin
            e = depth_cnt - 1;
            if (nm_len >= sec_len[e] || sec_name[e][nm_len] != b)
                nm_diff = 1'b1;
        end else begin
            nm_diff = 1'b1;
        end
        nm_len++;
    endfunction

    function automatic void name_char(logic [7:0] b);
        if (b == CH_RBRACE) begin
            sc_state = SC_NAME_RB;
        end else if (b == CH_LBRACE) begin
            add_name_byte(b);
            if (err_code == ST_OK)
                sc_state = SC_NAME_LB1;
        end else begin
            add_name_byte(b);
        end
    endfunction

    function automatic void end_tag();
        if (sc_kind == TAG_OPEN) begin
            if (depth_cnt >= DEPTH) begin
                latch_error(ST_STACK_FULL);
                return;
            end
            sec_len[depth_cnt]  = nm_len;
            sec_line[depth_cnt] = line_pos;
            sec_col[depth_cnt]  = col_pos;
            depth_cnt++;
        end else begin
            if (depth_cnt == 0) begin
                latch_error(ST_EMPTY_CLOSE);
                return;
            end
            if (nm_diff || nm_len != sec_len[depth_cnt-1]) begin
                latch_error(ST_MISMATCH);
                return;
            end
            depth_cnt--;
        end
        sc_state = SC_IDLE;
        sc_kind  = TAG_NONE;
    endfunction

    function automatic void scan_char(logic [7:0] b);
        case (sc_state)
            SC_IDLE: begin
                if (b == CH_LBRACE)
                    sc_state = SC_BRACE1;
            end
            SC_BRACE1: sc_state = (b == CH_LBRACE) ? SC_BRACE2 : SC_IDLE;
            SC_BRACE2: begin
                if (b == CH_HASH)
                    begin_tag(TAG_OPEN);
                else if (b == CH_SLASH)
                    begin_tag(TAG_CLOSE);
                else if (b != CH_LBRACE)
                    sc_state = SC_IDLE;
            end
            SC_NAME: name_char(b);
            SC_NAME_LB1: begin
                if (b == CH_LBRACE) begin
                    add_name_byte(b);
                    if (err_code == ST_OK)
                        sc_state = SC_NAME_LB2;
                end else begin
                    sc_state = SC_NAME;
                    name_char(b);
                end
            end
            SC_NAME_LB2: begin
                // a fresh tag start inside a name replaces the pending tag
                if (b == CH_HASH) begin
                    begin_tag(TAG_OPEN);
                end else if (b == CH_SLASH) begin
                    begin_tag(TAG_CLOSE);
                end else if (b == CH_LBRACE) begin
                    add_name_byte(b);
                end else begin
                    sc_state = SC_IDLE;
                    sc_kind  = TAG_NONE;
                end
            end
            SC_NAME_RB: begin
                if (b == CH_RBRACE) begin
                    end_tag();
                end else begin
                    // a lone closing brace belongs to the name
                    add_name_byte(CH_RBRACE);
                    if (err_code == ST_OK) begin
                        sc_state = SC_NAME;
                        name_char(b);
                    end
                end
            end
            default: begin
                sc_state = SC_IDLE;
                sc_kind  = TAG_NONE;
            end
        endcase
    endfunction

    function automatic t_nest_result predict_byte(logic [7:0] b, logic eof);
        t_nest_result r;
        r.line      = line_pos[PBITS-1:0];
        r.col       = col_pos[PBITS-1:0];
        r.open_line = '0;
        r.open_col  = '0;
        if (err_code == ST_OK)
            scan_char(b);
        r.status = err_code;
        if (eof && err_code == ST_OK && depth_cnt > 0)
            r.status = ST_UNFINISHED;
        r.depth = depth_cnt[DEPTH_W-1:0];
        if (depth_cnt > 0) begin
            r.open_line = sec_line[depth_cnt-1][PBITS-1:0];
            r.open_col  = sec_col[depth_cnt-1][PBITS-1:0];
        end
        if (b == CH_NEWLINE) begin
            if (line_pos < POS_MAX)
                line_pos++;
            col_pos = 0;
        end else if (col_pos < POS_MAX) begin
            col_pos++;
        end
        if (eof)
            clear_checker();
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        t_nest_result want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected (status %0d)", o_status);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("status", want.status, o_status);
        check_field("open_depth", want.depth, o_open_depth);
        check_field("line_number", want.line, o_line_number);
        check_field("column_number", want.col, o_column_number);
        check_field("opened_line", want.open_line, o_opened_line);
        check_field("opened_column", want.open_col, o_opened_column);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_name_byte();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return CH_NEWLINE;
        if (r < 6)
            return CH_LBRACE;
        if (r < 8)
            return CH_RBRACE;
        if (r < 14)
            return 8'($urandom_range(255));
        // narrow alphabet so that names often share prefixes
        return 8'h61 + 8'($urandom_range(5));
    endfunction

    function automatic void make_name(int idx, bit short_only);
        int r;
        r = $urandom_range(99);
        if (short_only || r < 85)
            gen_len[idx] = $urandom_range(0, 6);
        else if (r < 95)
            gen_len[idx] = $urandom_range(7, NBYTES);
        else
            gen_len[idx] = $urandom_range(NBYTES + 1, NBYTES + 2);
        for (int i = 0; i < gen_len[idx]; i++)
            gen_name[idx][i] = pick_name_byte();
    endfunction

    function automatic void emit_open(int idx);
        put_str(($urandom_range(9) == 0) ? "{{{#" : "{{#");
        for (int i = 0; i < gen_len[idx]; i++)
            text_q.push_back(gen_name[idx][i]);
        put_str("}}");
    endfunction

    // a spoilt close flips a byte, adds one or drops the last
    function automatic void emit_close(int idx, bit spoil);
        int len, pos, how;
        len = gen_len[idx];
        pos = $urandom_range(0, (len > 0) ? len - 1 : 0);
        how = $urandom_range(2);
        put_str("{{/");
        for (int i = 0; i < len; i++) begin
            if (spoil && how == 2 && i == len - 1)
                continue;
            if (spoil && how == 0 && i == pos)
                text_q.push_back(gen_name[idx][i] ^ 8'h01);
            else
                text_q.push_back(gen_name[idx][i]);
        end
        if (spoil && (how == 1 || len == 0))
            text_q.push_back(8'h6B);
        put_str("}}");
    endfunction

    function automatic void emit_text();
        int r;
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(99);
            if (r < 12)
                text_q.push_back(CH_NEWLINE);
            else if (r < 20)
                text_q.push_back(8'h20);
            else if (r < 26)
                text_q.push_back(8'($urandom_range(255)));
            else
                text_q.push_back(8'h61 + 8'($urandom_range(25)));
        end
    endfunction

    function automatic void emit_noise();
        case ($urandom_range(6))
            0: begin
                put_str("{{");
                text_q.push_back(8'h61 + 8'($urandom_range(25)));
            end
            1: put_str("}}");
            2: put_str("{{/z}}");
            3: begin
                // pending tag dropped by a brace pair inside its name
                put_str("{{#a{{");
                text_q.push_back(8'h61 + 8'($urandom_range(25)));
            end
            4: begin
                repeat ($urandom_range(1, 4))
                    text_q.push_back(8'($urandom_range(255)));
            end
            5: put_str("{{#n}x{y}}");
            default: put_str("{{/q{{#r}}");
        endcase
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic eof, input logic typed,
                             input t_nest_result want);
        t_nest_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        r = predict_byte(b, eof);
        expected_results.push_back(typed ? want : r);
    endtask

    task automatic feed_text_file();
        foreach (text_q[i])
            feed_byte(text_q[i], i == text_q.size() - 1, 1'b0, UNTYPED);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_results.size() != 0);
    endtask

    // one template file: mostly properly nested sections, some noise and spoilt tags
    task automatic gen_file();
        int top, r, n;
        text_q.delete();
        top = 0;
        if ($urandom_range(4) == 0) begin
            n = $urandom_range(DEPTH - 1, DEPTH + 1);
            for (int i = 0; i < n; i++) begin
                make_name(i, 1'b1);
                emit_open(i);
                if ($urandom_range(3) == 0)
                    emit_text();
            end
            top = n;
        end else begin
            repeat ($urandom_range(1, 30)) begin
                r = $urandom_range(99);
                if (r < 35 && top <= DEPTH) begin
                    make_name(top, 1'b0);
                    emit_open(top);
                    top++;
                end else if (r < 70 && top > 0) begin
                    if ($urandom_range(9) == 0) begin
                        emit_close(top - 1, 1'b1);
                    end else begin
                        emit_close(top - 1, 1'b0);
                        top--;
                    end
                end else if (r < 85) begin
                    emit_text();
                end else begin
                    emit_noise();
                end
            end
        end
        if ($urandom_range(4) != 0) begin
            while (top > 0) begin
                top--;
                emit_close(top, 1'b0);
            end
        end
        emit_text();
        if (text_q.size() == 0)
            text_q.push_back(8'h2E);
        feed_text_file();
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            check_result();
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        int phase_items;
        clear_checker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k])
            feed_byte(DIRECTED[k].text_byte, DIRECTED[k].eof, DIRECTED[k].typed,
                      DIRECTED[k].want);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            phase_items = 0;
            while (phase_items < 200) begin
                gen_file();
                phase_items += text_q.size();
            end
        end

        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("template_section_nesting_checker_tb OK");
        else
            $display("template_section_nesting_checker_tb NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("template_section_nesting_checker_tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tsnc_pkg.sv
hw/rtl/tsnc_front.sv
hw/rtl/tsnc_queue.sv
hw/rtl/tsnc_back.sv
hw/rtl/template_section_nesting_checker.sv
tb/template_section_nesting_checker_tb.sv
